// ===== design/rhcb_pkg.sv =====
// ----------------------------------------------------------------------------
// rhcb_pkg
// Shared types and constants of the rolling hash chunk boundary unit: hash
// constants, widths of the remainder datapath and its request/response structs.
// ----------------------------------------------------------------------------
package rhcb_pkg;

    // polynomial hash constants
    localparam int unsigned HASH_BASE = 257;
    localparam int unsigned HASH_MOD  = 1000000007;

    // widths
    localparam int HASH_W = 30;   // hash and remainder values, all below 2^30
    localparam int POS_W  = 32;   // byte positions and lengths
    localparam int MIN_W  = 16;   // minimum chunk length register
    localparam int ACC_W  = 46;   // remainder accumulator and shifted divisor
    localparam int CNT_W  = 4;    // radix-4 step counter

    // radix-4 step counts: hash reduction covers a quotient below 4^5,
    // boundary remainder covers a 30-bit dividend
    localparam logic [CNT_W-1:0] HASH_STEPS = CNT_W'(5);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(15);
    localparam int               DIV_SHIFT  = 28;

    // modulus aligned to the first radix-4 digit of the hash reduction
    localparam logic [ACC_W-1:0] HASH_DSH = ACC_W'(64'(HASH_MOD) << 8);
    // bias that keeps the hash update non-negative: 256 * modulus
    localparam logic [39:0]      MOD_BIAS = 40'(64'(HASH_MOD) * 64'd256);

    // request to the shared remainder unit
    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] dsh;
        logic [CNT_W-1:0] steps;
    } t_rem_req;

    // response of the shared remainder unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [HASH_W-1:0] rem;
    } t_rem_rsp;

endpackage

// ===== design/rhcb_radix4_rem.sv =====
// ----------------------------------------------------------------------------
// rhcb_radix4_rem
// Iterative radix-4 remainder unit. Each cycle subtracts the largest of
// 3d, 2d, d (d shifted to the current digit) that fits, then moves d down
// by one digit. Used for both the modular hash update and the boundary test.
// ----------------------------------------------------------------------------
module rhcb_radix4_rem
    import rhcb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_rsp o_rsp
);

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_dsh;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [ACC_W+1:0] acc_x;
    logic [ACC_W+1:0] d1;
    logic [ACC_W+1:0] d2;
    logic [ACC_W+1:0] d3;
    logic [ACC_W-1:0] n_acc;

    // one radix-4 digit: pick the largest multiple that fits
    always_comb begin
        acc_x = {2'b00, r_acc};
        d1    = {2'b00, r_dsh};
        d2    = {1'b0, r_dsh, 1'b0};
        d3    = d1 + d2;
        if (acc_x >= d3) begin
            n_acc = ACC_W'(acc_x - d3);
        end else if (acc_x >= d2) begin
            n_acc = ACC_W'(acc_x - d2);
        end else if (acc_x >= d1) begin
            n_acc = ACC_W'(acc_x - d1);
        end else begin
            n_acc = r_acc;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= i_req.acc;
            r_dsh <= i_req.dsh;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_dsh <= r_dsh >> 2;
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_acc[HASH_W-1:0];

endmodule

// ===== design/rolling_hash_chunk_boundary_unit.sv =====
// ----------------------------------------------------------------------------
// rolling_hash_chunk_boundary_unit
// Content-defined chunker: rolling hash over the last WINDOW bytes, a chunk boundary where the
// window is full, the chunk reaches the minimum length and the hash is divisible by that minimum.
// ----------------------------------------------------------------------------
// Flow: a byte is taken only once the previous one is done, paced by the shared radix-4 remainder
//   unit (5 steps for the modular hash update, 15 for the boundary test) and
//   the sequencer states; longer while an earlier chunk transaction is held.
// Sequence: a taken byte passes S_MUL, S_LOAD, S_HMOD, S_DMOD and S_EMIT, where its chunk is registered.
// Reset: synchronous, active low; clears positions, hash, output valid and
//   sets the minimum chunk length to 64. The window bytes are not cleared.
// ----------------------------------------------------------------------------
module rolling_hash_chunk_boundary_unit
    import rhcb_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // min_chunk_length
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // chunk stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] chunk_start, [63:32] chunk_length
    output logic        m_axis_tlast    // last_chunk
);

    // 257^n mod modulus, evaluated at elaboration
    function automatic logic [HASH_W-1:0] pow_mod(input int n);
        logic [63:0] w;
        w = 64'd1;
        for (int k = 0; k < n; k++) begin
            w = (w * 64'(HASH_BASE)) % 64'(HASH_MOD);
        end
        return w[HASH_W-1:0];
    endfunction

    // weight of the leaving byte after the next multiply by the base
    localparam logic [HASH_W-1:0] OLD_WEIGHT = pow_mod(WINDOW);
    localparam logic [POS_W-1:0]  WIN_LEN    = POS_W'(WINDOW);
    localparam logic [POS_W-1:0]  POS_MAX    = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_HMOD,
        S_DMOD,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [7:0]        r_window [WINDOW];
    logic [7:0]        r_byte;
    logic              r_last;
    logic              r_full;
    logic [37:0]       r_prod;
    logic [HASH_W-1:0] r_hash;
    logic [POS_W-1:0]  r_bytes_seen;
    logic [POS_W-1:0]  r_cur_start;
    logic [POS_W-1:0]  r_len;
    logic [MIN_W-1:0]  r_min;
    logic              r_rem_zero;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_start;
    logic [POS_W-1:0]  r_out_len;
    logic              r_out_last;

    t_rem_req          rem_req;
    t_rem_rsp          rem_rsp;
    logic [MIN_W-1:0]  divisor;
    logic [39:0]       hash_sum;
    logic              boundary;
    logic              out_free;

    // shared remainder unit
    rhcb_radix4_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    assign divisor  = (r_min == '0) ? MIN_W'(1) : r_min;
    assign out_free = !r_out_valid || m_axis_tready;

    // 257*h + byte - old*257^WINDOW, kept positive by the bias
    assign hash_sum = ({10'b0, r_hash} << 8) + {10'b0, r_hash} + {32'b0, r_byte}
                    + MOD_BIAS - {2'b0, r_prod};

    // requests to the remainder unit
    always_comb begin
        rem_req.start = 1'b0;
        rem_req.acc   = ACC_W'(hash_sum);
        rem_req.dsh   = HASH_DSH;
        rem_req.steps = HASH_STEPS;
        if (r_state == S_LOAD) begin
            rem_req.start = 1'b1;
        end else if (r_state == S_HMOD && rem_rsp.done) begin
            rem_req.start = 1'b1;
            rem_req.acc   = ACC_W'(rem_rsp.rem);
            rem_req.dsh   = ACC_W'({divisor, DIV_SHIFT'(0)});
            rem_req.steps = DIV_STEPS;
        end
    end

    // boundary test after the remainder is known
    assign boundary = (r_bytes_seen >= WIN_LEN) && (r_len != '0)
                    && (r_len >= POS_W'(r_min)) && r_rem_zero;

    // window shift line, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_window[0] <= r_byte;
            for (int k = 1; k < WINDOW; k++) begin
                r_window[k] <= r_window[k-1];
            end
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_W'(64);
        end else if (i_cfg_valid) begin
            r_min <= i_cfg_data;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hash       <= '0;
            r_bytes_seen <= '0;
            r_cur_start  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // output register: load a closed chunk, else release on handshake
            if (r_state == S_EMIT && out_free && (boundary || r_last)) begin
                r_out_valid <= 1'b1;
                r_out_start <= r_cur_start;
                r_out_len   <= (r_len == '0) ? POS_W'(1) : r_len;
                r_out_last  <= r_last;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_byte  <= s_axis_tdata;
                        r_last  <= s_axis_tlast;
                        r_full  <= (r_bytes_seen >= WIN_LEN);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= r_full ? (38'(r_window[WINDOW-1]) * 38'(OLD_WEIGHT)) : '0;
                    if (r_bytes_seen != POS_MAX) begin
                        r_bytes_seen <= r_bytes_seen + POS_W'(1);
                    end
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_len   <= r_bytes_seen - r_cur_start;
                    r_state <= S_HMOD;
                end
                S_HMOD: begin
                    if (rem_rsp.done) begin
                        r_hash  <= rem_rsp.rem;
                        r_state <= S_DMOD;
                    end
                end
                S_DMOD: begin
                    if (rem_rsp.done) begin
                        r_rem_zero <= (rem_rsp.rem == '0);
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_last) begin
                            r_hash       <= '0;
                            r_bytes_seen <= '0;
                            r_cur_start  <= '0;
                        end else if (boundary) begin
                            r_cur_start <= r_bytes_seen;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_start};
    assign m_axis_tlast  = r_out_last;

    // the block stays busy with a byte after taking it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("byte taken while previous byte still in work");

    // hash stays reduced
    a_hash_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hash < HASH_W'(HASH_MOD))
        else $error("rolling hash not reduced");

    // no empty chunk is reported
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:32] != 32'd0))
        else $error("zero-length chunk transaction");

    // remainder results arrive only while the sequencer waits for them
    a_rem_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_rsp.done |-> (r_state == S_HMOD || r_state == S_DMOD))
        else $error("remainder result with no request pending");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for rolling_hash_chunk_boundary_unit. A behavioral
// chunker predicts every chunk transaction as each byte is taken. A monitor
// compares the chunk stream field by field against that prediction. Directed
// documents come first, then phases of random documents under several
// minimum chunk lengths, with random gaps on the byte stream and back-pressure on the chunk stream.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              WINDOW      = 16;
    localparam longint unsigned POLY_BASE   = 257;
    localparam longint unsigned POLY_MOD    = 1000000007;
    localparam int              IDLE_CYCLES = 60;      // covers one byte in flight
    localparam int              CYCLE_LIMIT = 500000;
    localparam int              REPORT_MAX  = 10;

    // one chunk transaction
    typedef struct packed {
        logic [31:0] chunk_start;
        logic [31:0] chunk_length;
        logic        last_chunk;
    } t_chunk;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0; // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [31:0] chunk_start, [63:32] chunk_length
    logic        m_axis_tlast;         // last_chunk

    // behavioral chunker state
    logic [7:0]  recent_bytes [WINDOW];
    logic [29:0] window_hash   = '0;
    logic [31:0] doc_bytes     = '0;
    logic [31:0] open_start    = '0;
    logic [15:0] min_length    = 16'd64;

    t_chunk expected_chunks [$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     gaps_on     = 1'b1;
    bit     stalls_on   = 1'b1;
    int     stall_left  = 0;
    int     doc_left    = 0;

    rolling_hash_chunk_boundary_unit #(
        .WINDOW (WINDOW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chunks pending",
                     cycle_count, expected_chunks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // chunk stream back-pressure: mostly short stalls, a few long ones
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // update the chunker with one accepted byte and queue any chunk it closes
    task automatic predict_chunks(input logic [7:0] data_byte, input logic last_byte);
        longint unsigned acc;
        longint unsigned weight;
        logic [31:0]     count;
        logic [31:0]     len;
        logic [31:0]     divisor;
        t_chunk          chunk;
        acc = window_hash;
        // drop the oldest byte once the window is full
        if (doc_bytes >= WINDOW) begin
            weight = 1;
            for (int k = 0; k < WINDOW - 1; k++)
                weight = (weight * POLY_BASE) % POLY_MOD;
            acc = (acc + POLY_MOD - (recent_bytes[WINDOW-1] * weight) % POLY_MOD) % POLY_MOD;
        end
        acc = (acc * POLY_BASE + data_byte) % POLY_MOD;
        window_hash = acc[29:0];
        for (int k = WINDOW - 1; k > 0; k--)
            recent_bytes[k] = recent_bytes[k-1];
        recent_bytes[0] = data_byte;
        // saturating position
        count     = (doc_bytes == '1) ? '1 : doc_bytes + 1;
        doc_bytes = count;
        len       = count - open_start;
        divisor   = (min_length == 0) ? 32'd1 : 32'(min_length);
        if (count >= WINDOW && len >= 1 && len >= min_length &&
            (32'(window_hash) % divisor) == 0) begin
            chunk = '{chunk_start: open_start, chunk_length: len, last_chunk: last_byte};
            expected_chunks = {expected_chunks, chunk};
            open_start = count;
        end else if (last_byte) begin
            chunk = '{chunk_start: open_start, chunk_length: (len != 0) ? len : 32'd1,
                      last_chunk: 1'b1};
            expected_chunks = {expected_chunks, chunk};
        end
        // document end clears positions and hash
        if (last_byte) begin
            window_hash = '0;
            doc_bytes   = '0;
            open_start  = '0;
        end
    endtask

    // chunk monitor
    always @(posedge i_clk) begin
        t_chunk got;
        t_chunk want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{chunk_start: m_axis_tdata[31:0], chunk_length: m_axis_tdata[63:32],
                    last_chunk: m_axis_tlast};
            if (expected_chunks.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("%0t: unexpected chunk start=%0d length=%0d last=%0b",
                             $realtime, got.chunk_start, got.chunk_length, got.last_chunk);
            end else begin
                want = expected_chunks.pop_front();
                if (got.chunk_start !== want.chunk_start ||
                    got.chunk_length !== want.chunk_length ||
                    got.last_chunk !== want.last_chunk) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: chunk mismatch exp start=%0d length=%0d last=%0b",
                                 $realtime, want.chunk_start, want.chunk_length,
                                 want.last_chunk,
                                 " got start=%0d length=%0d last=%0b",
                                 got.chunk_start, got.chunk_length, got.last_chunk);
                end
            end
        end
    end

    // send one byte transaction, with an optional gap in front
    task automatic send_byte(input logic [7:0] data_byte, input logic last_byte);
        int gap;
        gap = 0;
        if (gaps_on)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data_byte;
        s_axis_tlast  <= last_byte;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_chunks(data_byte, last_byte);
    endtask

    // stop sending and wait until every predicted chunk has arrived
    task automatic drain_chunks(input int extra_cycles);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_chunks.size() != 0) @(posedge i_clk);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    // write the minimum chunk length while the unit is idle
    task automatic write_min_length(input logic [15:0] value);
        drain_chunks(IDLE_CYCLES);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        min_length = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // short documents under the reset minimum: each is one final chunk
    task automatic test_short_documents();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    // zero minimum: every full window closes a chunk, including on the last byte
    task automatic test_zero_minimum();
        write_min_length(16'd0);
        for (int k = 0; k < 18; k++)
            send_byte((k % 3 == 0) ? 8'h00 : (k % 3 == 1) ? 8'hFF : 8'($urandom),
                      k == 17);
    endtask

    // random documents under a series of minimum lengths
    task automatic test_random_documents();
        logic [15:0] settings [11];
        logic [7:0]  data_byte;
        settings = '{16'd1, 16'd2, 16'd65535, 16'd3, 16'd64, 16'd16, 16'd5,
                     16'd0, 16'($urandom_range(4, 40)), 16'd100, 16'd1};
        foreach (settings[p]) begin
            write_min_length(settings[p]);
            gaps_on   = (p % 4 != 1);
            stalls_on = (p % 4 != 2);
            for (int n = 0; n < 64; n++) begin
                if (doc_left == 0)
                    doc_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40)
                                                          : $urandom_range(41, 160);
                // some bytes are zero, the rest are random
                data_byte = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom);
                send_byte(data_byte, doc_left == 1);
                doc_left--;
                // hold off mid-stream until the chunk stream has caught up
                if ((p == 2 && n == 20) || $urandom_range(0, 59) == 0)
                    drain_chunks(0);
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_short_documents();
        test_zero_minimum();
        test_random_documents();
        drain_chunks(IDLE_CYCLES);
        error_count += expected_chunks.size();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rhcb_pkg.sv
design/rhcb_radix4_rem.sv
design/rolling_hash_chunk_boundary_unit.sv
verif/tb.sv
